[sv/ryuv_pkg.sv]
// Package with the shared types, constants and arithmetic helpers of the YUV411 converter.
`default_nettype none

package ryuv_pkg;

    // Output format code that selects YUV411 packing.
    localparam logic [1:0] FMT_YUV411 = 2'd2;

    // Luma weights.
    localparam logic [16:0] LUMA_R = 17'd55;
    localparam logic [16:0] LUMA_G = 17'd184;
    localparam logic [16:0] LUMA_B = 17'd19;
    localparam logic [16:0] LUMA_MAX = 17'd65535;

    // Chroma weights, bias and upper clamp.
    localparam logic signed [20:0] U_R = -21'sd29;
    localparam logic signed [20:0] U_G = -21'sd99;
    localparam logic signed [20:0] U_B = 21'sd128;
    localparam logic signed [20:0] V_R = 21'sd129;
    localparam logic signed [20:0] V_G = -21'sd116;
    localparam logic signed [20:0] V_B = -21'sd12;
    localparam logic signed [20:0] CHROMA_BIAS = 21'sd131072;
    localparam logic signed [20:0] CHROMA_MAX = 21'sd262143;

    // A closed group (or one passthrough pixel) waiting for the arithmetic stage.
    typedef struct packed {
        logic             rgb;
        logic [3:0][23:0] px;
        logic [1:0]       pos;
        logic             last;
        logic             user;
        logic [2:0]       keep;
        logic [2:0]       strb;
    } t_group;

    // One or two finished output words.
    typedef struct packed {
        logic [23:0] data0;
        logic        last0;
        logic        user0;
        logic [2:0]  keep0;
        logic [2:0]  strb0;
        logic        two;
        logic [23:0] data1;
        logic        last1;
    } t_words;

    function automatic logic [7:0] luma(input logic [23:0] px);
        logic [16:0] y;
        y = 17'(px[23:16]) * LUMA_R + 17'(px[7:0]) * LUMA_G + 17'(px[15:8]) * LUMA_B;
        if (y > LUMA_MAX) begin
            return 8'hFF;
        end
        return y[15:8];
    endfunction

    function automatic logic [7:0] chroma(input logic signed [20:0] v);
        if (v < 21'sd0) begin
            return 8'd0;
        end
        if (v > CHROMA_MAX) begin
            return 8'hFF;
        end
        return v[17:10];
    endfunction

endpackage

`default_nettype wire

[sv/ryuv_if.sv]
// Stream interfaces for the pixel input channel and the packed output channel.
`default_nettype none

interface ryuv_pixel_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_data;
    logic        pixel_last;
    logic        pixel_user;
    logic [2:0]  pixel_keep;
    logic [2:0]  pixel_strb;

    modport source (output valid, pixel_data, pixel_last, pixel_user, pixel_keep, pixel_strb,
                    input ready);
    modport sink (input valid, pixel_data, pixel_last, pixel_user, pixel_keep, pixel_strb,
                  output ready);
endinterface

interface ryuv_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] out_data;
    logic        out_last;
    logic        out_user;
    logic [2:0]  out_keep;
    logic [2:0]  out_strb;

    modport source (output valid, out_data, out_last, out_user, out_keep, out_strb,
                    input ready);
    modport sink (input valid, out_data, out_last, out_user, out_keep, out_strb,
                  output ready);
endinterface

`default_nettype wire

[sv/ryuv_pack.sv]
// Arithmetic stage: luma, chroma sums and word packing for one closed group.
`default_nettype none

module ryuv_pack (
    input  var ryuv_pkg::t_group i_grp,
    output var ryuv_pkg::t_words o_words
);

    logic [9:0]         sum_r;
    logic [9:0]         sum_g;
    logic [9:0]         sum_b;
    logic signed [20:0] u_val;
    logic signed [20:0] v_val;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 4; i++) begin
            sum_r = sum_r + 10'(i_grp.px[i][23:16]);
            sum_b = sum_b + 10'(i_grp.px[i][15:8]);
            sum_g = sum_g + 10'(i_grp.px[i][7:0]);
        end
    end

    assign u_val = $signed(21'(sum_r)) * ryuv_pkg::U_R + $signed(21'(sum_g)) * ryuv_pkg::U_G
                 + $signed(21'(sum_b)) * ryuv_pkg::U_B + ryuv_pkg::CHROMA_BIAS;
    assign v_val = $signed(21'(sum_r)) * ryuv_pkg::V_R + $signed(21'(sum_g)) * ryuv_pkg::V_G
                 + $signed(21'(sum_b)) * ryuv_pkg::V_B + ryuv_pkg::CHROMA_BIAS;

    always_comb begin
        if (i_grp.rgb) begin
            // Passthrough swaps the two low bytes.
            o_words.data0 = {i_grp.px[0][23:16], i_grp.px[0][7:0], i_grp.px[0][15:8]};
            o_words.last0 = i_grp.last;
            o_words.user0 = i_grp.user;
            o_words.keep0 = i_grp.keep;
            o_words.strb0 = i_grp.strb;
            o_words.two   = 1'b0;
        end else begin
            o_words.data0 = {ryuv_pkg::luma(i_grp.px[1]), ryuv_pkg::luma(i_grp.px[0]),
                             ryuv_pkg::chroma(u_val)};
            o_words.last0 = (i_grp.pos == 2'd0) ? i_grp.last : 1'b0;
            o_words.user0 = i_grp.user;
            o_words.keep0 = 3'b111;
            o_words.strb0 = 3'b111;
            o_words.two   = (i_grp.pos != 2'd0);
        end
        o_words.data1 = {ryuv_pkg::luma(i_grp.px[3]), ryuv_pkg::luma(i_grp.px[2]),
                         ryuv_pkg::chroma(v_val)};
        o_words.last1 = i_grp.last;
    end

endmodule

`default_nettype wire

[sv/rgb_to_yuv411_stream_core.sv]
// Top level of the streaming RGB to YUV411 converter.
`default_nettype none

// Streaming RGB to YUV411 converter. Each input beat carries one pixel (red in
// bits 23:16, blue in 15:8, green in 7:0). When the format register holds 2,
// pixels are gathered in groups of four and each group leaves as two beats:
// Y1,Y0,U and then Y3,Y2,V. A line end closes a group early; the missing
// pixels count as black, and a group closed on its first pixel sends only the
// first beat, which then carries the line end. Any other format value passes
// every pixel through with its two low bytes swapped, keeping keep and strobe.
// The block takes one pixel per clock while the group register is free or
// moving on. A pixel that opens or extends a group is absorbed into the
// holding registers at once. A pixel that closes a group moves into a group
// register, then through one stage of luma and chroma arithmetic into the
// result register, which takes it once the previous result is done; its first
// beat is then on the output port. The result register offers its second beat
// in the cycle after the first is taken, and while it does so the group
// register can already hold the next closed group. A full-rate stream of whole
// groups, or of passthrough pixels, never stalls. Runs of one- and two-pixel
// lines can ask for a beat on nearly every clock; the input is then held back
// now and then. Writing the format register drops a partly filled group; write
// it only while no beats are in flight.
module rgb_to_yuv411_stream_core (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    ryuv_pixel_if.sink      i_pixel,
    ryuv_out_if.source      o_out,
    input  var logic        i_cfg_we,
    input  var logic [1:0]  i_cfg_wdata
);

    // Format register and the open group.
    logic [1:0]        r_fmt;
    logic [2:0][23:0]  r_held;
    logic [1:0]        r_pos;
    logic              r_first_user;

    // Group register, ahead of the arithmetic.
    logic              r_g_vld;
    ryuv_pkg::t_group  r_grp;
    ryuv_pkg::t_group  n_grp;

    // Result register with its beat select.
    logic              r_r_vld;
    logic              r_sel;
    ryuv_pkg::t_words  r_words;
    ryuv_pkg::t_words  n_words;

    logic in_acc;
    logic out_acc;
    logic out_done;
    logic r_free;
    logic g_move;
    logic g_load;
    logic yuv_mode;
    logic closing;

    assign yuv_mode = (r_fmt == ryuv_pkg::FMT_YUV411);
    assign closing  = (r_pos == 2'd3) || i_pixel.pixel_last;

    assign in_acc   = i_pixel.valid && i_pixel.ready;
    assign out_acc  = o_out.valid && o_out.ready;
    // The result register empties once its last beat is taken.
    assign out_done = out_acc && (r_sel || !r_words.two);
    assign r_free   = !r_r_vld || out_done;
    assign g_move   = r_g_vld && r_free;
    // Only a pixel that finishes a group (or a passthrough pixel) needs the group register.
    assign g_load   = in_acc && (!yuv_mode || closing);

    assign i_pixel.ready = !r_g_vld || g_move;

    // Open group bookkeeping and the format register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= '0;
            r_pos        <= '0;
            r_first_user <= 1'b0;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
            r_pos <= '0;
        end else if (in_acc && yuv_mode) begin
            if (r_pos == 2'd0) begin
                r_first_user <= i_pixel.pixel_user;
            end
            r_pos <= closing ? 2'd0 : r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && yuv_mode && !closing) begin
            r_held[r_pos] <= i_pixel.pixel_data;
        end
    end

    // Assemble the closed group: held pixels, then this pixel, then black.
    always_comb begin
        n_grp.rgb  = !yuv_mode;
        n_grp.pos  = r_pos;
        n_grp.last = i_pixel.pixel_last;
        n_grp.user = (!yuv_mode || r_pos == 2'd0) ? i_pixel.pixel_user : r_first_user;
        n_grp.keep = i_pixel.pixel_keep;
        n_grp.strb = i_pixel.pixel_strb;
        if (!yuv_mode) begin
            n_grp.px    = '0;
            n_grp.px[0] = i_pixel.pixel_data;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (r_pos > 2'(i)) begin
                    n_grp.px[i] = r_held[i];
                end else if (r_pos == 2'(i)) begin
                    n_grp.px[i] = i_pixel.pixel_data;
                end else begin
                    n_grp.px[i] = '0;
                end
            end
            n_grp.px[3] = (r_pos == 2'd3) ? i_pixel.pixel_data : 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (g_load) begin
            r_g_vld <= 1'b1;
        end else if (g_move) begin
            r_g_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_load) begin
            r_grp <= n_grp;
        end
    end

    ryuv_pack u_pack (
        .i_grp   (r_grp),
        .o_words (n_words)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (g_move) begin
                r_r_vld <= 1'b1;
            end else if (out_done) begin
                r_r_vld <= 1'b0;
            end
            if (out_done) begin
                r_sel <= 1'b0;
            end else if (out_acc) begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_move) begin
            r_words <= n_words;
        end
    end

    assign o_out.valid    = r_r_vld;
    assign o_out.out_data = r_sel ? r_words.data1 : r_words.data0;
    assign o_out.out_last = r_sel ? r_words.last1 : r_words.last0;
    assign o_out.out_user = r_sel ? 1'b0 : r_words.user0;
    assign o_out.out_keep = r_sel ? 3'b111 : r_words.keep0;
    assign o_out.out_strb = r_sel ? 3'b111 : r_words.strb0;

    // The second beat is only ever selected for a two-beat group.
    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_vld && r_sel |-> r_words.two)
        else $error("second beat selected for a one-beat result");

    // Taking the first of two beats leaves the second one on the port.
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !r_sel && r_words.two |=> r_r_vld && r_sel)
        else $error("second beat lost after the first was taken");

    // A group leaving the group register always lands in the result register.
    a_group_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_move |=> r_r_vld && !r_sel)
        else $error("closed group did not reach the result register");

    // A closing or passthrough pixel is never taken while the group register is stuck.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_load && r_g_vld |-> g_move)
        else $error("group register overwritten before it moved on");

endmodule

`default_nettype wire

[tb/sv/rgb_to_yuv411_stream_core_tb.sv]
// Self-checking testbench for the streaming RGB to YUV411 converter.
`timescale 1ns / 1ps

module rgb_to_yuv411_stream_core_tb;

    // Format codes that select the byte-swapped RGB passthrough.
    localparam logic [1:0] FMT_RGB0 = 2'd0;
    localparam logic [1:0] FMT_RGB1 = 2'd1;
    localparam logic [1:0] FMT_RGB3 = 2'd3;

    // In YUV mode every output beat carries all three bytes.
    localparam logic [2:0] ALL_BYTES = 3'b111;

    // Cycles allowed for the pipeline to settle before the format register is written.
    localparam int SETTLE_CYCLES = 8;

    // Length of the deliberate output back-pressure stretch.
    localparam int LONG_HOLD_CYCLES = 80;

    localparam int NUM_PHASES = 7;

    // One beat on either channel: the payload fields share the same shape.
    typedef struct packed {
        logic [23:0] data;
        logic        last;
        logic        user;
        logic [2:0]  keep;
        logic [2:0]  strb;
    } t_beat;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_wdata;

    ryuv_pixel_if pix_if ();
    ryuv_out_if   out_if ();

    rgb_to_yuv411_stream_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pixel     (pix_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Pixels waiting for the driver, and pixels pushed but not yet taken by the block.
    t_beat pixels_to_send[$];
    int    pixels_outstanding = 0;

    // Output beats the converter model says must still arrive, oldest first.
    t_beat words_due[$];

    // Converter model state: format register, the open group and its user flag.
    logic [1:0]  fmt;
    logic [23:0] held_px [3];
    logic [1:0]  grp_pos;
    logic        grp_user;

    // Handshake bookkeeping between the clock edges.
    bit pix_taken = 1'b0;
    int send_gap = 0;
    int out_wait = 0;
    int hold_left = 0;
    bit long_hold_req = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    int error_count = 0;
    int pixels_accepted = 0;
    int beats_checked = 0;
    int format_writes = 0;

    // Phase plan for the random part: format, item count, and which side runs without idling.
    logic [1:0] phase_fmt [NUM_PHASES] = '{ryuv_pkg::FMT_YUV411, FMT_RGB0,
                                           ryuv_pkg::FMT_YUV411, FMT_RGB3,
                                           ryuv_pkg::FMT_YUV411, FMT_RGB1,
                                           ryuv_pkg::FMT_YUV411};
    int phase_items [NUM_PHASES] = '{130, 50, 130, 50, 130, 50, 130};
    bit phase_send_calm [NUM_PHASES] = '{0, 1, 1, 0, 1, 0, 0};
    bit phase_recv_calm [NUM_PHASES] = '{0, 0, 0, 0, 1, 1, 0};

    // Luma of one pixel: weighted sum saturated to 16 bits, top byte kept.
    function automatic logic [7:0] luma_of_pixel(input logic [23:0] p);
        int y;
        y = 55 * int'(p[23:16]) + 184 * int'(p[7:0]) + 19 * int'(p[15:8]);
        if (y > 65535) begin
            y = 65535;
        end
        return 8'(y >> 8);
    endfunction

    // Chroma from the biased group sum: clamped to 18 bits, then scaled down by 1024.
    function automatic logic [7:0] chroma_of_sum(input int v);
        if (v < 0) begin
            v = 0;
        end
        if (v > 262143) begin
            v = 262143;
        end
        return 8'(v >> 10);
    endfunction

    // Idle cycles before the next pixel or after an output beat. Most draws are zero
    // so that long back-to-back runs occur between the gaps.
    function automatic int draw_wait(input bit calm);
        if (calm || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Byte values lean toward the extremes so that the clamps are hit often.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Runs one accepted pixel through the converter model and queues the output
    // beats it causes. A pixel that only extends an open group causes none.
    task automatic convert_pixel(input t_beat b);
        t_beat       w;
        logic [23:0] grp [4];
        int          sr;
        int          sg;
        int          sb;
        if (fmt != ryuv_pkg::FMT_YUV411) begin
            w.data = {b.data[23:16], b.data[7:0], b.data[15:8]};
            w.last = b.last;
            w.user = b.user;
            w.keep = b.keep;
            w.strb = b.strb;
            words_due.push_back(w);
            return;
        end
        if (grp_pos == 2'd0) begin
            grp_user = b.user;
        end
        if (grp_pos < 2'd3 && !b.last) begin
            held_px[grp_pos] = b.data;
            grp_pos = grp_pos + 2'd1;
            return;
        end
        // The group closes here. Pixels past the closing one count as black.
        sr = 0;
        sg = 0;
        sb = 0;
        for (int i = 0; i < 4; i++) begin
            if (i < int'(grp_pos)) begin
                grp[i] = held_px[i];
            end else if (i == int'(grp_pos)) begin
                grp[i] = b.data;
            end else begin
                grp[i] = 24'h0;
            end
            sr += int'(grp[i][23:16]);
            sb += int'(grp[i][15:8]);
            sg += int'(grp[i][7:0]);
        end
        w.data = {luma_of_pixel(grp[1]), luma_of_pixel(grp[0]),
                  chroma_of_sum(-29 * sr - 99 * sg + 128 * sb + 131072)};
        w.last = (grp_pos == 2'd0) ? b.last : 1'b0;
        w.user = grp_user;
        w.keep = ALL_BYTES;
        w.strb = ALL_BYTES;
        words_due.push_back(w);
        // A line end on the group's first pixel sends the first beat alone.
        if (grp_pos != 2'd0) begin
            w.data = {luma_of_pixel(grp[3]), luma_of_pixel(grp[2]),
                      chroma_of_sum(129 * sr - 116 * sg - 12 * sb + 131072)};
            w.last = b.last;
            w.user = 1'b0;
            words_due.push_back(w);
        end
        grp_pos = 2'd0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic push_pixel(input logic [23:0] data, input logic last, input logic user,
                              input logic [2:0] keep, input logic [2:0] strb);
        pixels_to_send.push_back('{data: data, last: last, user: user, keep: keep,
                                   strb: strb});
        pixels_outstanding++;
    endtask

    // Waits until every pixel has been taken and every predicted beat has come out,
    // then gives a partly filled group time to settle in the block.
    task automatic wait_idle();
        while (pixels_outstanding != 0 || words_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_format(input logic [1:0] f);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= f;
        @(negedge clk);
        cfg_we <= 1'b0;
        format_writes++;
    endtask

    // Pixel driver. A presented beat holds until the monitor sees it taken; after
    // that the driver idles for the drawn gap before offering the next pixel.
    always @(negedge clk) begin : pixel_drive
        t_beat b;
        if (!rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_taken) begin
            pix_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                pix_if.valid <= 1'b0;
            end else if (pixels_to_send.size() > 0) begin
                b = pixels_to_send.pop_front();
                pix_if.valid <= 1'b1;
                pix_if.pixel_data <= b.data;
                pix_if.pixel_last <= b.last;
                pix_if.pixel_user <= b.user;
                pix_if.pixel_keep <= b.keep;
                pix_if.pixel_strb <= b.strb;
                send_gap = draw_wait(send_calm);
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Output ready. A requested long hold is counted down here first; otherwise
    // the stall drawn after the last output beat is served.
    always @(negedge clk) begin : out_ready_drive
        if (long_hold_req) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (out_wait > 0) begin
            out_wait--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor. Format writes and accepted pixels feed the converter model; every
    // accepted output beat is compared field by field with the oldest prediction.
    // Beats leave only once their pixel has passed the group and result registers,
    // so a push and a pop never meet on an empty prediction queue in one step.
    always @(posedge clk) begin : monitor
        t_beat due;
        if (!rst_n) begin
            fmt = FMT_RGB0;
            grp_pos = 2'd0;
            grp_user = 1'b0;
            for (int i = 0; i < 3; i++) begin
                held_px[i] = 24'h0;
            end
        end else begin
            if (cfg_we) begin
                // A format write drops any partly filled group.
                fmt = cfg_wdata;
                grp_pos = 2'd0;
            end
            if (pix_if.valid && pix_if.ready) begin
                convert_pixel('{data: pix_if.pixel_data, last: pix_if.pixel_last,
                                user: pix_if.pixel_user, keep: pix_if.pixel_keep,
                                strb: pix_if.pixel_strb});
                pix_taken = 1'b1;
                pixels_outstanding--;
                pixels_accepted++;
            end
            if (out_if.valid && out_if.ready) begin
                if (words_due.size() == 0) begin
                    report_mismatch("beat with nothing due, data", int'(out_if.out_data), 0);
                end else begin
                    due = words_due.pop_front();
                    if (out_if.out_data !== due.data) begin
                        report_mismatch("out_data", int'(out_if.out_data), int'(due.data));
                    end
                    if (out_if.out_last !== due.last) begin
                        report_mismatch("out_last", int'(out_if.out_last), int'(due.last));
                    end
                    if (out_if.out_user !== due.user) begin
                        report_mismatch("out_user", int'(out_if.out_user), int'(due.user));
                    end
                    if (out_if.out_keep !== due.keep) begin
                        report_mismatch("out_keep", int'(out_if.out_keep), int'(due.keep));
                    end
                    if (out_if.out_strb !== due.strb) begin
                        report_mismatch("out_strb", int'(out_if.out_strb), int'(due.strb));
                    end
                    beats_checked++;
                end
                out_wait = draw_wait(recv_calm);
            end
        end
    end

    // Stimulus. A short directed part covers the clamps, every way a group can
    // close, the user flag handling and a dropped partial group; then random
    // phases switch the format through all four values with varying flow control.
    initial begin : stimulus
        int len;
        int sent;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = FMT_RGB0;
        pix_if.valid = 1'b0;
        pix_if.pixel_data = 24'h0;
        pix_if.pixel_last = 1'b0;
        pix_if.pixel_user = 1'b0;
        pix_if.pixel_keep = 3'b000;
        pix_if.pixel_strb = 3'b000;
        out_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Passthrough in the reset format: extremes and mixed keep and strobe masks.
        push_pixel(24'h000000, 1'b0, 1'b0, 3'b000, 3'b000);
        push_pixel(24'hFFFFFF, 1'b1, 1'b1, 3'b111, 3'b111);
        push_pixel(24'h12AB34, 1'b0, 1'b1, 3'b101, 3'b010);
        push_pixel(24'hC35A0F, 1'b1, 1'b0, 3'b010, 3'b101);

        write_format(ryuv_pkg::FMT_YUV411);
        @(posedge clk);
        // White saturates luma; the group's user flag comes from its first pixel.
        for (int i = 0; i < 4; i++) begin
            push_pixel(24'hFFFFFF, 1'b0, i == 0, 3'b000, 3'b000);
        end
        // Pure red drives V past its clamp; the line end falls on the fourth pixel.
        for (int i = 0; i < 4; i++) begin
            push_pixel(24'hFF0000, i == 3, 1'b0, 3'b111, 3'b111);
        end
        // Pure blue alone on its line: only the first beat is sent, carrying last.
        push_pixel(24'h00FF00, 1'b1, 1'b1, 3'b011, 3'b100);
        // Lines that close the group after two and after three pixels.
        push_pixel(24'h0000FF, 1'b0, 1'b0, 3'b001, 3'b001);
        push_pixel(24'h00FF00, 1'b1, 1'b0, 3'b001, 3'b001);
        push_pixel(24'h123456, 1'b0, 1'b0, 3'b110, 3'b011);
        push_pixel(24'h89ABCD, 1'b0, 1'b1, 3'b110, 3'b011);
        push_pixel(24'hFEDCBA, 1'b1, 1'b0, 3'b110, 3'b011);
        // Black group: both chroma values sit at the bias.
        for (int i = 0; i < 4; i++) begin
            push_pixel(24'h000000, 1'b0, 1'b0, 3'b000, 3'b000);
        end
        // Two pixels left open; the format write that follows throws them away.
        push_pixel(24'hFFFFFF, 1'b0, 1'b1, 3'b000, 3'b000);
        push_pixel(24'hFFFFFF, 1'b0, 1'b0, 3'b000, 3'b000);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_format(phase_fmt[ph]);
            @(posedge clk);
            send_calm = phase_send_calm[ph];
            recv_calm = phase_recv_calm[ph];
            sent = 0;
            while (sent < phase_items[ph]) begin
                if (phase_fmt[ph] == ryuv_pkg::FMT_YUV411) begin
                    // Lines of random length, often whole groups, some short ones.
                    if ($urandom_range(0, 3) == 0) begin
                        len = 4 * $urandom_range(1, 3);
                    end else begin
                        len = $urandom_range(1, 13);
                    end
                    for (int k = 0; k < len; k++) begin
                        push_pixel({random_byte(), random_byte(), random_byte()},
                                   k == len - 1,
                                   (k == 0) ? ($urandom_range(0, 5) == 0)
                                            : ($urandom_range(0, 15) == 0),
                                   3'($urandom), 3'($urandom));
                    end
                    sent += len;
                end else begin
                    push_pixel({random_byte(), random_byte(), random_byte()},
                               $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)),
                               3'($urandom), 3'($urandom));
                    sent++;
                end
            end
            // In the full-rate YUV phase the output stalls for a long stretch
            // while the driver keeps offering pixels, so the block fills and
            // pushes back on its input.
            if (ph == 2) begin
                long_hold_req = 1'b1;
            end
        end

        wait_idle();
        $display("Checked %0d output beats from %0d pixels over %0d format writes,",
                 beats_checked, pixels_accepted, format_writes);
        $display("covering all four formats, short and full groups, and a long output stall.");
        if (error_count == 0) begin
            $display("rgb_to_yuv411_stream_core_tb: done, clean");
        end else begin
            $display("rgb_to_yuv411_stream_core_tb: done, errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #3_000_000;
        $display("Timed out with %0d pixels and %0d beats still pending.",
                 pixels_outstanding, words_due.size());
        $display("rgb_to_yuv411_stream_core_tb: done, errors");
        $finish;
    end

endmodule

[rgb_to_yuv411_stream_core.f]
sv/ryuv_pkg.sv
sv/ryuv_if.sv
sv/ryuv_pack.sv
sv/rgb_to_yuv411_stream_core.sv
tb/sv/rgb_to_yuv411_stream_core_tb.sv
